// ===== src/dgts_pkg.sv =====
// ---------------------------------------------------------------------------
// dgts_pkg
// Shared types, sizes and constants of the direct Gaussian transform sum.
// ---------------------------------------------------------------------------
package dgts_pkg;

    localparam int MAX_SOURCES = 256;
    localparam int MAX_DIMS    = 4;
    localparam int ADDR_W      = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CNT_W       = $clog2(MAX_SOURCES + 1);
    localparam int COORD_W     = 16;
    localparam int PT_W        = MAX_DIMS * COORD_W;
    localparam int ENTRY_W     = PT_W + COORD_W;
    localparam int SQ_W        = 32;
    localparam int DIST_W      = 34;
    localparam int IBW_W       = 16;
    localparam int TERM_W      = 33;
    localparam int SUM_W       = 48;

    // fixed-point constants of the exponential
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    localparam logic CFG_DIMS = 1'b0;
    localparam logic CFG_IBW  = 1'b1;

    // kernel pipeline status
    typedef struct packed {
        logic valid;
        logic busy;
    } t_kern_stat;

    // floor(2^34 / k) + 1, or exact for powers of two: floor(v/k) for v < 2^30
    function automatic logic [34:0] recip(input int k);
        logic [34:0] m;
        case (k)
            1:       m = 35'd17179869184;
            2:       m = 35'd8589934592;
            3:       m = 35'd5726623062;
            4:       m = 35'd4294967296;
            5:       m = 35'd3435973837;
            6:       m = 35'd2863311531;
            7:       m = 35'd2454267027;
            default: m = 35'd2147483648;
        endcase
        return m;
    endfunction

endpackage

// ===== src/dgts_ram.sv =====
// ---------------------------------------------------------------------------
// dgts_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module dgts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/dgts_lane.sv =====
// ---------------------------------------------------------------------------
// dgts_lane
// One distance lane: squared coordinate difference, registered.
// ---------------------------------------------------------------------------
module dgts_lane (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [dgts_pkg::COORD_W-1:0]  i_src,
    input  logic signed [dgts_pkg::COORD_W-1:0]  i_tgt,
    output logic [dgts_pkg::SQ_W-1:0]            o_sq
);
    import dgts_pkg::*;

    logic signed [COORD_W:0]     w_diff;
    logic signed [2*COORD_W+1:0] w_prod;
    logic [SQ_W-1:0]             r_sq;

    // difference is 17 bits, its square stays below 2^32
    assign w_diff = {i_src[COORD_W-1], i_src} - {i_tgt[COORD_W-1], i_tgt};
    assign w_prod = w_diff * w_diff;

    always_ff @(posedge i_clk) begin
        r_sq <= i_en ? w_prod[SQ_W-1:0] : '0;
    end

    assign o_sq = r_sq;
endmodule

// ===== src/dgts_kernel.sv =====
// ---------------------------------------------------------------------------
// dgts_kernel
// Pipelined exp(-dist * inv_bandwidth_sq) in Q0.16 times the source weight.
// ---------------------------------------------------------------------------
module dgts_kernel (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [dgts_pkg::DIST_W-1:0]         i_dist,
    input  logic [dgts_pkg::IBW_W-1:0]          i_ibw,
    input  logic signed [dgts_pkg::COORD_W-1:0] i_weight,
    output dgts_pkg::t_kern_stat                o_stat,
    output logic signed [dgts_pkg::TERM_W-1:0]  o_term
);
    import dgts_pkg::*;

    localparam int X_W = DIST_W + IBW_W;

    // stage 1: x = dist * ibw
    logic               r_v1;
    logic [X_W-1:0]     r_x1;
    logic [15:0]        r_w1;
    // stage 2: y = x * log2(e)
    logic               r_v2, r_z2;
    logic [28:0]        r_y2;
    logic [15:0]        r_w2;
    // stage 3: t = frac * ln2
    logic               r_v3, r_z3;
    logic [4:0]         r_n3;
    logic [29:0]        r_t3;
    logic [15:0]        r_w3;

    logic [58:0]        w_yprod;
    logic [53:0]        w_tprod;

    assign w_yprod = r_x1[27:0] * LOG2E_Q30;
    assign w_tprod = r_y2[23:0] * LN2_Q30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_x1 <= i_dist * i_ibw;
        r_w1 <= i_weight;
        r_z2 <= |r_x1[X_W-1:28];
        r_y2 <= w_yprod[58:30];
        r_w2 <= r_w1;
        r_z3 <= r_z2;
        r_n3 <= r_y2[28:24];
        r_t3 <= w_tprod[53:24];
        r_w3 <= r_w2;
    end

    // Horner chain, k = 8 down to 1, two stages per step
    logic        w_hv [9];
    logic        w_hz [9];
    logic [4:0]  w_hn [9];
    logic [29:0] w_ht [9];
    logic [30:0] w_hr [9];
    logic [15:0] w_hw [9];

    assign w_hv[0] = r_v3;
    assign w_hz[0] = r_z3;
    assign w_hn[0] = r_n3;
    assign w_ht[0] = r_t3;
    assign w_hr[0] = ONE_Q30;
    assign w_hw[0] = r_w3;

    logic [8:0] w_step_busy;
    assign w_step_busy[0] = 1'b0;

    for (genvar s = 0; s < 8; s++) begin : g_step
        localparam logic [34:0] M = recip(8 - s);
        logic        r_va, r_vb, r_za, r_zb;
        logic [4:0]  r_na, r_nb;
        logic [29:0] r_ta, r_tb;
        logic [15:0] r_wa, r_wb;
        logic [60:0] r_p;
        logic [30:0] r_r;
        logic [65:0] w_q;

        assign w_q = r_p[60:30] * M;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_va <= 1'b0;
                r_vb <= 1'b0;
            end else begin
                r_va <= w_hv[s];
                r_vb <= r_va;
            end
            r_za <= w_hz[s];
            r_na <= w_hn[s];
            r_ta <= w_ht[s];
            r_wa <= w_hw[s];
            r_p  <= w_ht[s] * w_hr[s];
            r_zb <= r_za;
            r_nb <= r_na;
            r_tb <= r_ta;
            r_wb <= r_wa;
            r_r  <= ONE_Q30 - w_q[64:34];
        end

        assign w_hv[s+1] = r_vb;
        assign w_hz[s+1] = r_zb;
        assign w_hn[s+1] = r_nb;
        assign w_ht[s+1] = r_tb;
        assign w_hr[s+1] = r_r;
        assign w_hw[s+1] = r_wb;
        assign w_step_busy[s+1] = r_va | r_vb;
    end

    // scale by 2^-n, round to Q0.16, saturate
    logic        r_vf, r_vg;
    logic [15:0] r_kf, r_wf;
    logic signed [TERM_W-1:0] r_term;
    logic [30:0] w_shift;
    logic [16:0] w_round;

    assign w_shift = w_hr[8] >> w_hn[8];
    assign w_round = 17'((32'(w_shift) + 32'd8192) >> 14);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
            r_vg <= 1'b0;
        end else begin
            r_vf <= w_hv[8];
            r_vg <= r_vf;
        end
        if (w_hz[8]) begin
            r_kf <= '0;
        end else begin
            r_kf <= w_round[16] ? 16'hFFFF : w_round[15:0];
        end
        r_wf   <= w_hw[8];
        r_term <= $signed(r_wf) * $signed({1'b0, r_kf});
    end

    assign o_term       = r_term;
    assign o_stat.valid = r_vg;
    assign o_stat.busy  = r_v1 | r_v2 | r_v3 | (|w_step_busy) | r_vf | r_vg;
endmodule

// ===== src/direct_gauss_transform_sum.sv =====
// ---------------------------------------------------------------------------
// direct_gauss_transform_sum
// Source store plus weighted Gaussian kernel sum over all stored sources.
//
//  channel  dir  handshake               payload
//  s        in   i_s_tvalid/o_s_tready   tdata coords+weight, tuser action
//  m        out  o_m_tvalid/i_m_tready   tdata sum+count, tuser status
//  cfg      in   i_cfg_valid/o_cfg_ready index + data
//
// Clear, load and unused actions go from idle straight to the done state.
// In a query, one stored source is read from the RAM each cycle and enters
// the lane/kernel pipeline, then the pipeline drains.
// Reset is synchronous and empties the store (count only); no clearing pass.
// A result waiting at the output does not stop the next item from being taken.
// ---------------------------------------------------------------------------
module direct_gauss_transform_sum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,   // coord_0, coord_1, coord_2, coord_3, weight
    input  logic [1:0]  i_s_tuser,   // action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // sum[47:0], stored_count[56:48], zero fill
    output logic [0:0]  o_m_tuser,   // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import dgts_pkg::*;

    t_state r_state, n_state;

    logic [2:0]             r_dims;
    logic [IBW_W-1:0]       r_ibw;
    logic [CNT_W-1:0]       r_count;
    logic [ADDR_W-1:0]      r_idx;
    logic [PT_W-1:0]        r_tgt;
    logic signed [SUM_W-1:0] r_acc;
    logic                   r_status;
    logic                   r_rd_vld, r_lane_vld, r_dist_vld;
    logic [DIST_W-1:0]      r_dist;
    logic [15:0]            r_w_lane, r_w_dist;
    logic                   r_out_valid;
    logic [SUM_W-1:0]       r_out_sum;
    logic [CNT_W-1:0]       r_out_cnt;
    logic                   r_out_status;

    logic        w_accept, w_full, w_last, w_out_free, w_busy, w_we, w_issue;
    t_action     w_act;
    logic [2:0]  w_nd;
    logic [ENTRY_W-1:0] w_rdata;
    logic [SQ_W-1:0]    w_sq [MAX_DIMS];
    logic [DIST_W-1:0]  n_dist_sum;
    t_kern_stat  w_kstat;
    logic signed [TERM_W-1:0] w_term;

    assign w_act      = t_action'(i_s_tuser);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count >= CNT_W'(MAX_SOURCES));
    assign w_last     = ({1'b0, r_idx} == (r_count - CNT_W'(1)));
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_busy     = r_rd_vld | r_lane_vld | r_dist_vld | w_kstat.busy;
    assign w_we       = w_accept && (w_act == ACT_LOAD) && !w_full;
    assign o_cfg_ready = 1'b1;

    // effective dimension count
    always_comb begin
        if (r_dims == 3'd0) begin
            w_nd = 3'd1;
        end else if (r_dims > 3'(MAX_DIMS)) begin
            w_nd = 3'(MAX_DIMS);
        end else begin
            w_nd = r_dims;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (w_act == ACT_QUERY && r_count != '0) ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN:   if (w_last) n_state = ST_DRAIN;
            ST_DRAIN: if (!w_busy) n_state = ST_DONE;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_issue    = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_s_tready = 1'b1;
            ST_RUN:   w_issue    = 1'b1;
            ST_DRAIN,
            ST_DONE:  ;
            default:  ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dims      <= 3'd3;
            r_ibw       <= 16'd256;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_lane_vld  <= 1'b0;
            r_dist_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= w_issue;
            r_lane_vld <= r_rd_vld;
            r_dist_vld <= r_lane_vld;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_DIMS) begin
                    r_dims <= i_cfg_data[2:0];
                end else begin
                    r_ibw <= i_cfg_data;
                end
            end
            if (w_accept && w_act == ACT_CLEAR) begin
                r_count <= '0;
            end else if (w_we) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item registers and accumulator
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tgt    <= i_s_tdata[PT_W-1:0];
            r_status <= (w_act == ACT_LOAD) && w_full;
            r_idx    <= '0;
        end else if (w_issue) begin
            r_idx <= r_idx + ADDR_W'(1);
        end
        if (w_accept) begin
            r_acc <= '0;
        end else if (w_kstat.valid) begin
            r_acc <= r_acc + SUM_W'(w_term);
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_sum    <= r_acc;
            r_out_cnt    <= r_count;
            r_out_status <= r_status;
        end
    end

    dgts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SOURCES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_s_tdata[79:64], i_s_tdata[PT_W-1:0]}),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // distance lanes
    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
        dgts_lane u_lane (
            .i_clk (i_clk),
            .i_en  (3'(d) < w_nd),
            .i_src (w_rdata[d*COORD_W +: COORD_W]),
            .i_tgt (r_tgt[d*COORD_W +: COORD_W]),
            .o_sq  (w_sq[d])
        );
    end

    // merge: sum of lane squares
    always_comb begin
        logic [DIST_W-1:0] s;
        s = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            s = s + DIST_W'(w_sq[d]);
        end
        n_dist_sum = s;
    end

    always_ff @(posedge i_clk) begin
        r_w_lane <= w_rdata[ENTRY_W-1:PT_W];
        r_w_dist <= r_w_lane;
        r_dist   <= n_dist_sum;
    end

    dgts_kernel u_kernel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_dist_vld),
        .i_dist   (r_dist),
        .i_ibw    (r_ibw),
        .i_weight (r_w_dist),
        .o_stat   (w_kstat),
        .o_term   (w_term)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(64-SUM_W-CNT_W){1'b0}}, r_out_cnt, r_out_sum};
    assign o_m_tuser  = r_out_status;

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !w_busy)
        else $error("input taken while the pipeline is busy");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SOURCES))
        else $error("stored count beyond capacity");
    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_count != '0))
        else $error("walk over an empty store");
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ST_IDLE))
        else $error("store written outside idle");
`endif
endmodule
